### hw/rtl/sha256_stream_hasher_assert.svh
// Assertion macros shared by the checker file of the SHA-256 hasher.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ssh_pkg.sv
// Widths, codes, constant tables and mixing functions for the SHA-256 hasher.
`timescale 1ns / 1ps
package ssh_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos = 56;
  localparam int unsigned Rounds    = 64;
  localparam int unsigned LenW      = 64;

  typedef logic [WordW-1:0] word_t;

  // tuser code on the input side
  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinish = 1'b1;

  localparam logic [ByteW-1:0] PadMark = 8'h80;

  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher: byte absorb, padding, iterative compression, digest out.
//
//  channel | dir | tdata                | tuser           | tlast
//  s_axis  | in  | [7:0] data_byte      | [0] func        | -
//  m_axis  | out | [31:0] digest_word   | [2:0] word_index| last_word
//
// Absorb items are taken while idle; the 64th byte of a block starts a compression of
// 64 rounds through the single round unit, one cycle per round, plus the hash add.
// A finish item compresses the padded block, and a second block when the padding spills,
// then eight digest items leave one per cycle while m_axis_tready_i is high.
// Input is not ready while compressing or while the digest is out; output stalls
// simply hold the current word. Reset loads the initial hash values at once.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [ssh_pkg::ByteW-1:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic                       s_axis_tuser_i,  // [0] func
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [ssh_pkg::WordW-1:0]  m_axis_tdata_o,  // [31:0] digest_word
  output logic [ssh_pkg::IdxW-1:0]   m_axis_tuser_o,  // [2:0] word_index
  output logic                       m_axis_tlast_o   // last_word
);
  import ssh_pkg::*;

  typedef enum logic [2:0] {StIdle, StRound, StFinal, StPad, StOut} state_e;
  typedef enum logic [1:0] {NxIdle, NxPad, NxOut} after_e;

  state_e               state_q;
  after_e               after_q;
  logic [5:0]           round_q;
  logic [5:0]           fill_q;
  logic [LenW-1:0]      total_q;
  logic [IdxW-1:0]      idx_q;
  word_t                hash_q [8];
  word_t                w_q [BlockWords];
  word_t                r_q [8];

  logic                 in_acc, out_acc, absorb, finish, block_full;
  logic [LenW-1:0]      bit_len;
  word_t                pad_w [BlockWords];
  word_t                pad2_w [BlockWords];
  word_t                r_d [8];
  word_t                t1, t2, w_new;

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = hash_q[0];
  assign m_axis_tuser_o  = idx_q;
  assign m_axis_tlast_o  = (idx_q == IdxW'(7));

  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc    = m_axis_tvalid_o && m_axis_tready_i;
  assign absorb     = in_acc && (s_axis_tuser_i == FuncAbsorb);
  assign finish     = in_acc && (s_axis_tuser_i == FuncFinish);
  assign block_full = (fill_q == 6'(BlockBytes - 1));
  assign bit_len    = {total_q[LenW-4:0], 3'b000};

  // padded blocks built in one go: keep held bytes, mark, zero the rest, bit length last
  always_comb begin
    for (int j = 0; j < BlockBytes; j++) begin
      if (6'(j) < fill_q) begin
        pad_w[j/4][(3 - j%4)*8 +: 8] = w_q[j/4][(3 - j%4)*8 +: 8];
      end else if (6'(j) == fill_q) begin
        pad_w[j/4][(3 - j%4)*8 +: 8] = PadMark;
      end else begin
        pad_w[j/4][(3 - j%4)*8 +: 8] = '0;
      end
    end
    if (fill_q < 6'(LengthPos)) begin
      pad_w[BlockWords-2] = bit_len[LenW-1:WordW];
      pad_w[BlockWords-1] = bit_len[WordW-1:0];
    end
    for (int k = 0; k < BlockWords; k++) begin
      pad2_w[k] = '0;
    end
    pad2_w[BlockWords-2] = bit_len[LenW-1:WordW];
    pad2_w[BlockWords-1] = bit_len[WordW-1:0];
  end

  // the shared round unit and the schedule expansion
  always_comb begin
    t1 = r_q[7] + big_sig1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
       + RoundK[round_q] + w_q[0];
    t2 = big_sig0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
    r_d[0] = t1 + t2;
    r_d[1] = r_q[0];
    r_d[2] = r_q[1];
    r_d[3] = r_q[2];
    r_d[4] = r_q[3] + t1;
    r_d[5] = r_q[4];
    r_d[6] = r_q[5];
    r_d[7] = r_q[6];
    w_new  = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
  end

  // sequencer and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      after_q <= NxIdle;
      round_q <= '0;
      fill_q  <= '0;
      total_q <= '0;
      idx_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= HashInit[i];
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          round_q <= '0;
          if (absorb) begin
            fill_q  <= fill_q + 6'd1;
            total_q <= total_q + LenW'(1);
            if (block_full) begin
              after_q <= NxIdle;
              state_q <= StRound;
            end
          end else if (finish) begin
            after_q <= (fill_q >= 6'(LengthPos)) ? NxPad : NxOut;
            state_q <= StRound;
          end
        end
        StRound: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'(Rounds - 1)) begin
            state_q <= StFinal;
          end
        end
        StFinal: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + r_q[i];
          end
          idx_q <= '0;
          unique case (after_q)
            NxIdle:  state_q <= StIdle;
            NxPad:   state_q <= StPad;
            NxOut:   state_q <= StOut;
            default: state_q <= StIdle;
          endcase
        end
        StPad: begin
          round_q <= '0;
          after_q <= NxOut;
          state_q <= StRound;
        end
        StOut: begin
          if (out_acc) begin
            idx_q <= idx_q + IdxW'(1);
            if (m_axis_tlast_o) begin
              for (int i = 0; i < 8; i++) begin
                hash_q[i] <= HashInit[i];
              end
              fill_q  <= '0;
              total_q <= '0;
              state_q <= StIdle;
            end else begin
              for (int i = 0; i < 7; i++) begin
                hash_q[i] <= hash_q[i+1];
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // block buffer / schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (absorb) begin
      w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= s_axis_tdata_i;
    end
    if (absorb && block_full) begin
      r_q <= hash_q;
    end
    if (finish) begin
      w_q <= pad_w;
      r_q <= hash_q;
    end
    if (state_q == StPad) begin
      w_q <= pad2_w;
      r_q <= hash_q;
    end
    if (state_q == StRound) begin
      r_q <= r_d;
      for (int k = 0; k < BlockWords - 1; k++) begin
        w_q[k] <= w_q[k+1];
      end
      w_q[BlockWords-1] <= w_new;
    end
  end

endmodule

### hw/rtl/ssh_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_assert.svh"
module ssh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [ssh_pkg::WordW-1:0]  m_axis_tdata_o,
  input logic [ssh_pkg::IdxW-1:0]   m_axis_tuser_o,
  input logic                       m_axis_tlast_o
);
  import ssh_pkg::*;

  logic            out_acc, word_step, word_end, stall, last_idx;
  logic [IdxW-1:0] idx_nx;
  assign out_acc   = m_axis_tvalid_o && m_axis_tready_i;
  assign word_step = out_acc && !m_axis_tlast_o;
  assign word_end  = out_acc && m_axis_tlast_o;
  assign stall     = m_axis_tvalid_o && !m_axis_tready_i;
  assign last_idx  = (m_axis_tuser_o == IdxW'(7));
  assign idx_nx    = m_axis_tuser_o + IdxW'(1);

  // never take input while a digest is being delivered
  `SSH_ASSERT_NOW(a_excl, m_axis_tvalid_o, !s_axis_tready_o, "input ready during digest")
  // tlast marks exactly the eighth word
  `SSH_ASSERT_NOW(a_last, m_axis_tvalid_o, m_axis_tlast_o == last_idx, "tlast mismatch")
  // words come back to back in index order
  `SSH_ASSERT_NEXT(a_order, word_step, m_axis_tvalid_o && m_axis_tuser_o == $past(idx_nx), "word order")
  // after the last word the block is ready for a new message
  `SSH_ASSERT_NEXT(a_done, word_end, s_axis_tready_o && !m_axis_tvalid_o, "not idle after digest")
  // stalled word holds
  `SSH_ASSERT_NEXT(a_hold, stall, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled word changed")

endmodule

bind sha256_stream_hasher ssh_checker u_ssh_checker (.*);
